FILE: src/itt_pkg.sv
// itt_pkg: shared constants and codes for the incubator thermostat and turner
// no dependencies; imported by incubator_thermostat_turner
`default_nettype none

package itt_pkg;

	// motor steps in one full revolution
	localparam int STEPS_PER_REV = 200;

	// fixed point scale: one converter count is 0.4883 degrees
	localparam int COUNT_SCALE   = 4883;
	localparam int DEGREE_SCALE  = 10000;

	localparam int HOURS_PER_DAY = 24;
	localparam int LAST_MINUTE   = 59;
	localparam int LAST_HOUR     = 23;

	// field widths
	localparam int TEMP_W   = 10;
	localparam int HOUR_W   = 5;
	localparam int MINUTE_W = 6;
	localparam int IDEAL_W  = 6;
	localparam int BAND_W   = 4;
	localparam int PERIOD_W = 5;
	localparam int STEPS_W  = 8;
	localparam int POS_W    = $clog2(STEPS_PER_REV);

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;

	// scaled temperature widths
	localparam int TSCALED_W = TEMP_W + $clog2(COUNT_SCALE);
	localparam int DSCALED_W = IDEAL_W + 1 + $clog2(DEGREE_SCALE);
	localparam int CMP_W     = (TSCALED_W > DSCALED_W) ? TSCALED_W : DSCALED_W;

	// conditional subtracts needed to bring position plus steps below a revolution
	localparam int MOD_PASSES = (STEPS_PER_REV - 1 + 255) / STEPS_PER_REV;
	localparam int SUM_W      = STEPS_W + 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_IDEAL_TEMP     = 3'd0,
		CFG_BAND           = 3'd1,
		CFG_TURN_PERIOD    = 3'd2,
		CFG_STEPS_PER_TURN = 3'd3,
		CFG_MANUAL_MODE    = 3'd4,
		CFG_MANUAL_HEATER  = 3'd5,
		CFG_MANUAL_COOLER  = 3'd6
	} cfg_index_t;

	typedef enum logic {
		OP_TICK      = 1'b0,
		OP_CLOCK_SET = 1'b1
	} op_t;

	typedef struct packed {
		logic [HOUR_W-1:0]   hour;
		logic [MINUTE_W-1:0] minute;
	} clock_time_t;

endpackage

`default_nettype wire

FILE: src/incubator_thermostat_turner.sv
// incubator_thermostat_turner: hysteresis heater/cooler control and egg turn scheduler
// depends on itt_pkg (constants, config codes, time struct)
// registered path: input register, then result register
// throughput: one request per cycle while out_ready is high; thermostat and turn state
// update as an item leaves the input register, so the next item already sees it
// reset: asynchronous, clears pipeline valids, flags, motor position and schedule,
// and loads configuration defaults
`default_nettype none

module incubator_thermostat_turner (
	input  wire logic                              clk,
	input  wire logic                              arst_n,

	input  wire logic                              cfg_write,
	input  wire logic [itt_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [itt_pkg::CFG_DATA_W-1:0]    cfg_data,

	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic                              operation,
	input  wire logic [itt_pkg::TEMP_W-1:0]        temp_raw,
	input  wire logic [itt_pkg::HOUR_W-1:0]        hour,
	input  wire logic [itt_pkg::MINUTE_W-1:0]      minute,

	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic                                   heater_on,
	output logic                                   cooler_on,
	output logic                                   turn_now,
	output logic [itt_pkg::STEPS_W-1:0]            turn_steps,
	output logic [itt_pkg::POS_W-1:0]              motor_position,
	output logic [itt_pkg::HOUR_W-1:0]             next_hour,
	output logic [itt_pkg::MINUTE_W-1:0]           next_minute
);
	import itt_pkg::*;

	// configuration registers
	logic [IDEAL_W-1:0]  ideal_temp_q;
	logic [BAND_W-1:0]   band_q;
	logic [PERIOD_W-1:0] turn_period_q;
	logic [STEPS_W-1:0]  steps_per_turn_q;
	logic                manual_mode_q;
	logic                manual_heater_q;
	logic                manual_cooler_q;

	// block state
	logic              heating_q;
	logic              cooling_q;
	logic [POS_W-1:0]  position_q;
	clock_time_t       turn_time_q;

	// input register
	logic                valid_s1;
	op_t                 operation_s1;
	logic [TEMP_W-1:0]   temp_raw_s1;
	clock_time_t         now_s1;

	// result register
	logic                out_valid_q;
	logic                heater_on_q;
	logic                cooler_on_q;
	logic                turn_now_q;
	logic [STEPS_W-1:0]  turn_steps_q;
	logic [POS_W-1:0]    position_out_q;
	clock_time_t         next_time_q;

	logic advance;
	logic fire_s1;

	// next values computed from the input register
	logic              heating_d;
	logic              cooling_d;
	logic              turn_hit;
	logic [POS_W-1:0]  position_d;
	clock_time_t       turn_time_d;
	clock_time_t       resched_time;

	logic [CMP_W-1:0]  temp_scaled;
	logic [CMP_W-1:0]  ideal_scaled;
	logic [CMP_W-1:0]  low_scaled;
	logic [CMP_W-1:0]  high_scaled;
	logic              low_valid;
	logic [IDEAL_W:0]  low_deg;
	logic [IDEAL_W:0]  high_deg;

	// (hour + period) mod 24, with the one-minute step back for a full-day period
	function automatic clock_time_t reschedule(input clock_time_t now,
			input logic [PERIOD_W-1:0] period);
		logic [HOUR_W:0]     sum;
		logic [HOUR_W-1:0]   h;
		logic [MINUTE_W-1:0] m;
		clock_time_t         r;
		sum = {1'b0, now.hour} + (HOUR_W+1)'(period);
		if (sum >= (HOUR_W+1)'(2 * HOURS_PER_DAY)) begin
			h = HOUR_W'(sum - (HOUR_W+1)'(2 * HOURS_PER_DAY));
		end else if (sum >= (HOUR_W+1)'(HOURS_PER_DAY)) begin
			h = HOUR_W'(sum - (HOUR_W+1)'(HOURS_PER_DAY));
		end else begin
			h = HOUR_W'(sum);
		end
		m = now.minute;
		if (period == PERIOD_W'(HOURS_PER_DAY)) begin
			if (m == '0) begin
				m = MINUTE_W'(LAST_MINUTE);
				h = (h == '0) ? HOUR_W'(LAST_HOUR) : h - HOUR_W'(1);
			end else begin
				m = m - MINUTE_W'(1);
			end
		end
		r.hour   = h;
		r.minute = m;
		return r;
	endfunction

	function automatic logic [POS_W-1:0] advance_position(input logic [POS_W-1:0] pos,
			input logic [STEPS_W-1:0] steps);
		logic [SUM_W-1:0] acc;
		acc = SUM_W'(pos) + SUM_W'(steps);
		for (int i = 0; i < MOD_PASSES; i++) begin
			if (acc >= SUM_W'(STEPS_PER_REV)) begin
				acc = acc - SUM_W'(STEPS_PER_REV);
			end
		end
		return POS_W'(acc);
	endfunction

	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;
	assign fire_s1  = valid_s1 && advance;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ideal_temp_q     <= IDEAL_W'(30);
			band_q           <= BAND_W'(5);
			turn_period_q    <= PERIOD_W'(6);
			steps_per_turn_q <= STEPS_W'(50);
			manual_mode_q    <= 1'b0;
			manual_heater_q  <= 1'b0;
			manual_cooler_q  <= 1'b0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_IDEAL_TEMP:     ideal_temp_q     <= cfg_data[IDEAL_W-1:0];
				CFG_BAND:           band_q           <= cfg_data[BAND_W-1:0];
				CFG_TURN_PERIOD:    turn_period_q    <= cfg_data[PERIOD_W-1:0];
				CFG_STEPS_PER_TURN: steps_per_turn_q <= cfg_data[STEPS_W-1:0];
				CFG_MANUAL_MODE:    manual_mode_q    <= cfg_data[0];
				CFG_MANUAL_HEATER:  manual_heater_q  <= cfg_data[0];
				CFG_MANUAL_COOLER:  manual_cooler_q  <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// temperature compare in exact fixed point: raw*4883 against degrees*10000
	always_comb begin
		low_valid    = ideal_temp_q > IDEAL_W'(band_q);
		low_deg      = (IDEAL_W+1)'(ideal_temp_q) - (IDEAL_W+1)'(band_q);
		high_deg     = (IDEAL_W+1)'(ideal_temp_q) + (IDEAL_W+1)'(band_q);
		temp_scaled  = CMP_W'(temp_raw_s1) * CMP_W'(COUNT_SCALE);
		ideal_scaled = CMP_W'(ideal_temp_q) * CMP_W'(DEGREE_SCALE);
		low_scaled   = CMP_W'(low_deg) * CMP_W'(DEGREE_SCALE);
		high_scaled  = CMP_W'(high_deg) * CMP_W'(DEGREE_SCALE);
	end

	always_comb begin
		heating_d    = heating_q;
		cooling_d    = cooling_q;
		position_d   = position_q;
		turn_time_d  = turn_time_q;
		resched_time = reschedule(now_s1, turn_period_q);
		turn_hit     = (now_s1 == turn_time_q);

		case (operation_s1)
			OP_CLOCK_SET: begin
				turn_hit    = 1'b0;
				turn_time_d = resched_time;
			end
			default: begin
				if (manual_mode_q) begin
					heating_d = manual_heater_q;
					cooling_d = manual_cooler_q;
				end else begin
					// ideal minus band below zero never sets the heater
					if (low_valid && temp_scaled < low_scaled) begin
						heating_d = 1'b1;
					end else if (temp_scaled >= ideal_scaled) begin
						heating_d = 1'b0;
					end
					if (temp_scaled > high_scaled) begin
						cooling_d = 1'b1;
					end else if (temp_scaled <= ideal_scaled) begin
						cooling_d = 1'b0;
					end
				end
				if (turn_hit) begin
					position_d  = advance_position(position_q, steps_per_turn_q);
					turn_time_d = resched_time;
				end
			end
		endcase
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			operation_s1  <= op_t'(operation);
			temp_raw_s1   <= temp_raw;
			now_s1.hour   <= hour;
			now_s1.minute <= minute;
		end
	end

	// state update as the item leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heating_q   <= 1'b0;
			cooling_q   <= 1'b0;
			position_q  <= '0;
			turn_time_q <= '0;
		end else if (fire_s1) begin
			heating_q   <= heating_d;
			cooling_q   <= cooling_d;
			position_q  <= position_d;
			turn_time_q <= turn_time_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			heater_on_q    <= heating_d;
			cooler_on_q    <= cooling_d;
			turn_now_q     <= turn_hit;
			turn_steps_q   <= turn_hit ? steps_per_turn_q : '0;
			position_out_q <= position_d;
			next_time_q    <= turn_time_d;
		end
	end

	assign out_valid      = out_valid_q;
	assign heater_on      = heater_on_q;
	assign cooler_on      = cooler_on_q;
	assign turn_now       = turn_now_q;
	assign turn_steps     = turn_steps_q;
	assign motor_position = position_out_q;
	assign next_hour      = next_time_q.hour;
	assign next_minute    = next_time_q.minute;

endmodule

`default_nettype wire

FILE: test/incubator_thermostat_turner_test.sv
// incubator_thermostat_turner_test: self-checking bench for the thermostat and egg turner
// depends on itt_pkg and incubator_thermostat_turner; directed rows, then randomized settings
// and requests; results checked against a cycle-free model of the block or fixed expected values
`default_nettype none

module incubator_thermostat_turner_test;
	timeunit 1ns;
	timeprecision 1ps;

	import itt_pkg::*;

	localparam int STALL_LIMIT = 1000;
	localparam int PHASES = 10;
	localparam int REQUESTS_PER_PHASE = 70;
	// index past the last register, writes to it must change nothing
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

	typedef struct packed {
		logic                heater;
		logic                cooler;
		logic                turn;
		logic [STEPS_W-1:0]  steps;
		logic [POS_W-1:0]    pos;
		logic [HOUR_W-1:0]   hr;
		logic [MINUTE_W-1:0] mn;
	} turner_status_t;

	typedef struct packed {
		bit                    is_setting;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] val;
		op_t                   op;
		logic [TEMP_W-1:0]     raw;
		logic [HOUR_W-1:0]     hr;
		logic [MINUTE_W-1:0]   mn;
		bit                    typed;
		turner_status_t        want;
	} probe_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_write;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic operation;
	logic [TEMP_W-1:0] temp_raw;
	logic [HOUR_W-1:0] hour;
	logic [MINUTE_W-1:0] minute;
	logic out_valid;
	logic out_ready;
	logic heater_on;
	logic cooler_on;
	logic turn_now;
	logic [STEPS_W-1:0] turn_steps;
	logic [POS_W-1:0] motor_position;
	logic [HOUR_W-1:0] next_hour;
	logic [MINUTE_W-1:0] next_minute;

	// model copy of settings and state
	logic [IDEAL_W-1:0] ideal_deg;
	logic [BAND_W-1:0] band_deg;
	logic [PERIOD_W-1:0] period_hr;
	logic [STEPS_W-1:0] steps_turn;
	logic manual_on, manual_heat, manual_cool;
	logic heat_flag, cool_flag;
	logic [POS_W-1:0] motor_pos;
	logic [HOUR_W-1:0] sched_hour;
	logic [MINUTE_W-1:0] sched_minute;

	turner_status_t status_due[$];
	probe_row_t probes[$];

	int mismatches = 0;
	int results_checked = 0;
	int requests_sent = 0;
	int clock_sets = 0;
	int turns_fired = 0;
	int settings_loaded = 0;
	int quiet_cycles = 0;

	incubator_thermostat_turner dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.temp_raw(temp_raw),
		.hour(hour),
		.minute(minute),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.heater_on(heater_on),
		.cooler_on(cooler_on),
		.turn_now(turn_now),
		.turn_steps(turn_steps),
		.motor_position(motor_position),
		.next_hour(next_hour),
		.next_minute(next_minute)
	);

	always #4 clk = ~clk;

	function automatic void plan_turn(input logic [HOUR_W-1:0] hr, input logic [MINUTE_W-1:0] mn);
		int h;
		int m;
		h = (int'(hr) + int'(period_hr)) % HOURS_PER_DAY;
		m = int'(mn);
		// a full-day period lands one minute early so the turn does not repeat on the same tick
		if (period_hr == HOURS_PER_DAY) begin
			if (m == 0) begin
				m = LAST_MINUTE;
				h = (h == 0) ? LAST_HOUR : h - 1;
			end else begin
				m = m - 1;
			end
		end
		sched_hour = HOUR_W'(h);
		sched_minute = MINUTE_W'(m);
	endfunction

	function automatic turner_status_t step_incubator(input op_t op, input logic [TEMP_W-1:0] raw,
			input logic [HOUR_W-1:0] hr, input logic [MINUTE_W-1:0] mn);
		turner_status_t res;
		int scaled, ideal, low_edge, high_edge;
		res = '0;
		if (op == OP_CLOCK_SET) begin
			plan_turn(hr, mn);
		end else begin
			if (manual_on) begin
				heat_flag = manual_heat;
				cool_flag = manual_cool;
			end else begin
				scaled = int'(raw) * COUNT_SCALE;
				ideal = int'(ideal_deg) * DEGREE_SCALE;
				low_edge = (int'(ideal_deg) - int'(band_deg)) * DEGREE_SCALE;
				high_edge = (int'(ideal_deg) + int'(band_deg)) * DEGREE_SCALE;
				if (scaled < low_edge)
					heat_flag = 1'b1;
				else if (scaled >= ideal)
					heat_flag = 1'b0;
				if (scaled > high_edge)
					cool_flag = 1'b1;
				else if (scaled <= ideal)
					cool_flag = 1'b0;
			end
			if (hr == sched_hour && mn == sched_minute) begin
				res.turn = 1'b1;
				res.steps = steps_turn;
				motor_pos = POS_W'((int'(motor_pos) + int'(steps_turn)) % STEPS_PER_REV);
				plan_turn(hr, mn);
				turns_fired++;
			end
		end
		res.heater = heat_flag;
		res.cooler = cool_flag;
		res.pos = motor_pos;
		res.hr = sched_hour;
		res.mn = sched_minute;
		return res;
	endfunction

	// samples near the heat, target and cool thresholds, or anywhere
	function automatic logic [TEMP_W-1:0] pick_raw();
		int base;
		case ($urandom_range(3))
			0: return TEMP_W'($urandom_range(1023));
			1: base = (int'(ideal_deg) - int'(band_deg)) * DEGREE_SCALE / COUNT_SCALE;
			2: base = int'(ideal_deg) * DEGREE_SCALE / COUNT_SCALE;
			default: base = (int'(ideal_deg) + int'(band_deg)) * DEGREE_SCALE / COUNT_SCALE;
		endcase
		base = base + int'($urandom_range(6)) - 3;
		if (base < 0)
			base = 0;
		if (base > 1023)
			base = 1023;
		return TEMP_W'(base);
	endfunction

	function automatic probe_row_t setting_row(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		probe_row_t row;
		row = '0;
		row.is_setting = 1'b1;
		row.idx = idx;
		row.val = val;
		return row;
	endfunction

	function automatic probe_row_t request_row(input op_t op, input logic [TEMP_W-1:0] raw,
			input logic [HOUR_W-1:0] hr, input logic [MINUTE_W-1:0] mn);
		probe_row_t row;
		row = '0;
		row.op = op;
		row.raw = raw;
		row.hr = hr;
		row.mn = mn;
		return row;
	endfunction

	function automatic probe_row_t known_row(input op_t op, input logic [TEMP_W-1:0] raw,
			input logic [HOUR_W-1:0] hr, input logic [MINUTE_W-1:0] mn, input turner_status_t want);
		probe_row_t row;
		row = request_row(op, raw, hr, mn);
		row.typed = 1'b1;
		row.want = want;
		return row;
	endfunction

	task automatic write_setting(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			CFG_IDEAL_TEMP: ideal_deg = val[IDEAL_W-1:0];
			CFG_BAND: band_deg = val[BAND_W-1:0];
			CFG_TURN_PERIOD: period_hr = val[PERIOD_W-1:0];
			CFG_STEPS_PER_TURN: steps_turn = val;
			CFG_MANUAL_MODE: manual_on = val[0];
			CFG_MANUAL_HEATER: manual_heat = val[0];
			CFG_MANUAL_COOLER: manual_cool = val[0];
			default: ;
		endcase
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_settings(input logic [7:0] ideal, input logic [7:0] bnd,
			input logic [7:0] period, input logic [7:0] steps, input logic [7:0] manual,
			input logic [7:0] heat, input logic [7:0] cool);
		write_setting(CFG_IDEAL_TEMP, ideal);
		write_setting(CFG_BAND, bnd);
		write_setting(CFG_TURN_PERIOD, period);
		write_setting(CFG_STEPS_PER_TURN, steps);
		write_setting(CFG_MANUAL_MODE, manual);
		write_setting(CFG_MANUAL_HEATER, heat);
		write_setting(CFG_MANUAL_COOLER, cool);
		settings_loaded++;
	endtask

	// stop offering, wait for every outstanding result, then let the pipeline empty
	task automatic settle_block();
		in_valid <= 1'b0;
		while (status_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic offer_request(input op_t op, input logic [TEMP_W-1:0] raw,
			input logic [HOUR_W-1:0] hr, input logic [MINUTE_W-1:0] mn, input bit typed,
			input turner_status_t want);
		turner_status_t due;
		in_valid <= 1'b1;
		operation <= op;
		temp_raw <= raw;
		hour <= hr;
		minute <= mn;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		due = step_incubator(op, raw, hr, mn);
		status_due.push_back(typed ? want : due);
		requests_sent++;
		if (op == OP_CLOCK_SET)
			clock_sets++;
	endtask

	always @(posedge clk) begin : check_status
		turner_status_t want;
		if (arst_n && out_valid && out_ready) begin
			if (status_due.size() == 0) begin
				$error("result arrived with no request outstanding");
				mismatches++;
			end else begin
				want = status_due.pop_front();
				results_checked++;
				if (heater_on !== want.heater) begin
					$error("heater_on: expected %0d, got %0d", want.heater, heater_on);
					mismatches++;
				end
				if (cooler_on !== want.cooler) begin
					$error("cooler_on: expected %0d, got %0d", want.cooler, cooler_on);
					mismatches++;
				end
				if (turn_now !== want.turn) begin
					$error("turn_now: expected %0d, got %0d", want.turn, turn_now);
					mismatches++;
				end
				if (turn_steps !== want.steps) begin
					$error("turn_steps: expected %0d, got %0d", want.steps, turn_steps);
					mismatches++;
				end
				if (motor_position !== want.pos) begin
					$error("motor_position: expected %0d, got %0d", want.pos, motor_position);
					mismatches++;
				end
				if (next_hour !== want.hr) begin
					$error("next_hour: expected %0d, got %0d", want.hr, next_hour);
					mismatches++;
				end
				if (next_minute !== want.mn) begin
					$error("next_minute: expected %0d, got %0d", want.mn, next_minute);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("timeout: no request moved for %0d cycles", STALL_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// receiver: stretches of random stalls, full-rate stretches, and a long hold-off now and then
	initial begin : receiver
		int seg, len, pct;
		out_ready = 1'b0;
		seg = 0;
		wait (arst_n === 1'b1);
		forever begin
			seg++;
			if (seg % 6 == 0) begin
				len = 64;
				pct = 0;
			end else begin
				len = $urandom_range(60, 8);
				case ($urandom_range(3))
					0: pct = 100;
					1: pct = 75;
					2: pct = 50;
					default: pct = 25;
				endcase
			end
			repeat (len) begin
				@(posedge clk);
				out_ready <= ($urandom_range(99) < pct);
			end
		end
	end

	initial begin : stimulus
		probe_row_t row;
		op_t op;
		logic [HOUR_W-1:0] hr;
		logic [MINUTE_W-1:0] mn;
		int burst, gap, pick;

		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		operation = OP_TICK;
		temp_raw = '0;
		hour = '0;
		minute = '0;
		ideal_deg = 30;
		band_deg = 5;
		period_hr = 6;
		steps_turn = 50;
		manual_on = 1'b0;
		manual_heat = 1'b0;
		manual_cool = 1'b0;
		heat_flag = 1'b0;
		cool_flag = 1'b0;
		motor_pos = '0;
		sched_hour = '0;
		sched_minute = '0;

		// reset settings: target 30, band 5, period 6, 50 steps, first turn at midnight
		probes.push_back(known_row(OP_TICK, 10'd0, 5'd0, 6'd0,
			{1'b1, 1'b0, 1'b1, 8'd50, 8'd50, 5'd6, 6'd0}));
		probes.push_back(known_row(OP_TICK, 10'd1023, 5'd23, 6'd59,
			{1'b0, 1'b1, 1'b0, 8'd0, 8'd50, 5'd6, 6'd0}));
		probes.push_back(known_row(OP_CLOCK_SET, 10'd0, 5'd31, 6'd63,
			{1'b0, 1'b1, 1'b0, 8'd0, 8'd50, 5'd13, 6'd63}));
		probes.push_back(request_row(OP_TICK, 10'd61, 5'd13, 6'd63));
		// manual mode forces both flags, hysteresis resumes from them
		probes.push_back(setting_row(CFG_MANUAL_MODE, 8'd1));
		probes.push_back(setting_row(CFG_MANUAL_HEATER, 8'd1));
		probes.push_back(setting_row(CFG_MANUAL_COOLER, 8'd1));
		probes.push_back(request_row(OP_TICK, 10'd512, 5'd5, 6'd5));
		probes.push_back(setting_row(CFG_MANUAL_MODE, 8'd0));
		probes.push_back(request_row(OP_TICK, 10'd61, 5'd1, 6'd1));
		// full-day period: minute moves back, midnight wraps to the last minute of the day
		probes.push_back(setting_row(CFG_TURN_PERIOD, 8'd24));
		probes.push_back(request_row(OP_CLOCK_SET, 10'd0, 5'd0, 6'd0));
		probes.push_back(request_row(OP_TICK, 10'd0, 5'd23, 6'd59));
		probes.push_back(request_row(OP_CLOCK_SET, 10'd300, 5'd5, 6'd30));
		probes.push_back(request_row(OP_TICK, 10'd70, 5'd5, 6'd29));
		// zero period turns on every matching tick, oversized step count wraps
		probes.push_back(setting_row(CFG_TURN_PERIOD, 8'd0));
		probes.push_back(setting_row(CFG_STEPS_PER_TURN, 8'd255));
		probes.push_back(request_row(OP_CLOCK_SET, 10'd0, 5'd7, 6'd7));
		probes.push_back(request_row(OP_TICK, 10'd61, 5'd7, 6'd7));
		probes.push_back(request_row(OP_TICK, 10'd62, 5'd7, 6'd7));
		// heat threshold below zero never heats
		probes.push_back(setting_row(CFG_IDEAL_TEMP, 8'd0));
		probes.push_back(request_row(OP_TICK, 10'd0, 5'd12, 6'd0));
		probes.push_back(request_row(OP_TICK, 10'd1, 5'd12, 6'd0));
		probes.push_back(setting_row(CFG_IDEAL_TEMP, 8'd63));
		probes.push_back(setting_row(CFG_BAND, 8'd15));
		probes.push_back(request_row(OP_TICK, 10'd0, 5'd12, 6'd0));
		probes.push_back(request_row(OP_TICK, 10'd1023, 5'd12, 6'd0));
		probes.push_back(setting_row(CFG_STEPS_PER_TURN, 8'd0));
		probes.push_back(request_row(OP_TICK, 10'd400, 5'd7, 6'd7));
		probes.push_back(setting_row(CFG_SPARE, 8'hFF));
		probes.push_back(request_row(OP_TICK, 10'd700, 5'd31, 6'd63));

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (probes[i]) begin
			row = probes[i];
			if (row.is_setting) begin
				settle_block();
				write_setting(row.idx, row.val);
			end else begin
				offer_request(row.op, row.raw, row.hr, row.mn, row.typed, row.want);
			end
		end

		for (int phase = 0; phase < PHASES; phase++) begin
			settle_block();
			case (phase)
				0: load_settings(8'd10, 8'd1, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0);
				1: load_settings(8'd60, 8'd9, 8'd24, 8'd200, 8'd0, 8'd1, 8'd1);
				// every data bit high, upper bits must be dropped
				2: load_settings(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFE, 8'hFF, 8'hFF);
				default: load_settings(
					8'(($urandom_range(3) != 0) ? $urandom_range(60, 10) : $urandom_range(255)),
					8'(($urandom_range(3) != 0) ? $urandom_range(9, 1) : $urandom_range(255)),
					8'(($urandom_range(3) != 0) ? $urandom_range(24, 1) : $urandom_range(255)),
					8'(($urandom_range(3) != 0) ? $urandom_range(200) : $urandom_range(255)),
					($urandom_range(99) < 20) ? 8'd1 : 8'd0,
					8'($urandom_range(255)), 8'($urandom_range(255)));
			endcase
			burst = $urandom_range(30, 1);
			for (int n = 0; n < REQUESTS_PER_PHASE; n++) begin
				pick = $urandom_range(99);
				if (pick < 35) begin
					// land on the scheduled turn time
					op = OP_TICK;
					hr = sched_hour;
					mn = sched_minute;
				end else begin
					op = (pick < 45) ? OP_CLOCK_SET : OP_TICK;
					if ($urandom_range(99) < 85) begin
						hr = HOUR_W'($urandom_range(23));
						mn = MINUTE_W'($urandom_range(59));
					end else begin
						hr = HOUR_W'($urandom_range(31));
						mn = MINUTE_W'($urandom_range(63));
					end
				end
				offer_request(op, pick_raw(), hr, mn, 1'b0, '0);
				burst--;
				if (burst == 0) begin
					burst = $urandom_range(30, 1);
					gap = ($urandom_range(99) < 30) ? 0 : $urandom_range(8, 1);
					if (gap != 0) begin
						in_valid <= 1'b0;
						repeat (gap) @(posedge clk);
					end
				end
			end
		end

		settle_block();
		repeat (8) @(posedge clk);
		if (status_due.size() != 0) begin
			$error("%0d results never arrived", status_due.size());
			mismatches++;
		end
		$display("covered %0d requests (%0d clock sets, %0d turns) under %0d settings",
			requests_sent, clock_sets, turns_fired, settings_loaded);
		$display("checked %0d results, %0d mismatches", results_checked, mismatches);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

`default_nettype wire
